[rtl/grc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_pkg: shared definitions for the grid ray-cast column core
// Fixed-point formats, field widths, register indexes, opcodes and the
// control bundle of the shared divider.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int ONE_FX        = 1 << FRAC_BITS;
    localparam int MAP_SIDE_DEF  = 64;
    localparam int MAX_STEPS_DEF = 128;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 22;
    localparam int POS_W     = 22;
    localparam int VEC_W     = 19;
    localparam int SCR_W     = 13;
    localparam int CELL_W    = 6;
    localparam int COL_W     = 12;
    localparam int ROW_W     = 12;
    localparam int DIST_W    = 32;
    localparam int H_MAX     = 4096;

    localparam int COL2_W = COL_W + 1;
    localparam int CAM_W  = COL2_W + FRAC_BITS;
    localparam int CMW    = CAM_W + 1;
    localparam int RW     = 2 * FRAC_BITS + 3;
    localparam int DTW    = 2 * FRAC_BITS + 1;
    localparam int FW     = FRAC_BITS + 1;
    localparam int MA     = VEC_W;
    localparam int MB     = DTW + 1;
    localparam int PROD_W = MA + MB;
    localparam int LNW    = SCR_W + FRAC_BITS;

    localparam int DIV_CNT_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_W   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCR_H   = 3'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } t_div_ctl;

endpackage

[rtl/grid_raycast_column_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_raycast_column_core: one-column DDA ray caster over a wall map
// Holds a square map of wall bits, loaded one cell per item, and casts one
// screen column per item: ray setup, DDA walk, distance and wall span.
// ----------------------------------------------------------------------------
//  Channel | Valid    | Stall    | Payload
//  --------+----------+----------+--------------------------------------------
//  in      | i_valid  | o_stall  | i_opcode i_cell_x i_cell_y i_wall i_column
//  out     | o_valid  | i_stall  | o_column_out o_draw_start o_draw_end o_side
//          |          |          | o_hit_x o_hit_y o_perp_dist o_no_hit
//  cfg     | i_cfg_we | -        | i_cfg_idx i_cfg_data
//
// A cast runs up to five divisions on the shared bit-serial divider, one
// quotient bit per cycle, and walks at most MAX_STEPS grid steps, each
// waiting on the registered map read. Reset is synchronous and active low
// and leaves the map contents undefined. The input is stalled for the whole
// cast; a finished result waits in the output register while the next item
// is taken.
// ----------------------------------------------------------------------------
module grid_raycast_column_core import grc_pkg::*; #(
    parameter int MAP_SIDE  = MAP_SIDE_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_opcode,
    input  logic [CELL_W-1:0]    i_cell_x,
    input  logic [CELL_W-1:0]    i_cell_y,
    input  logic                 i_wall,
    input  logic [COL_W-1:0]     i_column,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [COL_W-1:0]     o_column_out,
    output logic [ROW_W-1:0]     o_draw_start,
    output logic [ROW_W-1:0]     o_draw_end,
    output logic                 o_side,
    output logic [CELL_W-1:0]    o_hit_x,
    output logic [CELL_W-1:0]    o_hit_y,
    output logic [DIST_W-1:0]    o_perp_dist,
    output logic                 o_no_hit
);

    localparam int CW    = (($clog2(MAP_SIDE) > CELL_W) ? $clog2(MAP_SIDE) : CELL_W) + 2;
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PNW   = CW + FRAC_BITS + 2;
    localparam int DNW   = PNW + FRAC_BITS;
    localparam int NSW   = $clog2(MAX_STEPS + 1);
    localparam int SW    = DTW + NSW;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CAM   = 5'd1;
    localparam logic [4:0] S_CAMW  = 5'd2;
    localparam logic [4:0] S_MX    = 5'd3;
    localparam logic [4:0] S_MY    = 5'd4;
    localparam logic [4:0] S_RY    = 5'd5;
    localparam logic [4:0] S_DX    = 5'd6;
    localparam logic [4:0] S_DXW   = 5'd7;
    localparam logic [4:0] S_DY    = 5'd8;
    localparam logic [4:0] S_DYW   = 5'd9;
    localparam logic [4:0] S_SX    = 5'd10;
    localparam logic [4:0] S_SY    = 5'd11;
    localparam logic [4:0] S_SYW   = 5'd12;
    localparam logic [4:0] S_STEP  = 5'd13;
    localparam logic [4:0] S_CHK   = 5'd14;
    localparam logic [4:0] S_PERP  = 5'd15;
    localparam logic [4:0] S_PERPW = 5'd16;
    localparam logic [4:0] S_LINE  = 5'd17;
    localparam logic [4:0] S_LINEW = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;

    logic [4:0]              r_state;
    logic [POS_W-1:0]        r_pos_x;
    logic [POS_W-1:0]        r_pos_y;
    logic signed [VEC_W-1:0] r_dir_x;
    logic signed [VEC_W-1:0] r_dir_y;
    logic signed [VEC_W-1:0] r_plane_x;
    logic signed [VEC_W-1:0] r_plane_y;
    logic [SCR_W-1:0]        r_scr_w;
    logic [SCR_W-1:0]        r_scr_h;

    logic [COL_W-1:0]         r_col;
    logic signed [CMW-1:0]    r_cam;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RW-1:0]     r_rx;
    logic signed [RW-1:0]     r_ry;
    logic [DTW-1:0]           r_dx;
    logic [DTW-1:0]           r_dy;
    logic [SW-1:0]            r_sx;
    logic [SW-1:0]            r_sy;
    logic signed [CW-1:0]     r_cx;
    logic signed [CW-1:0]     r_cy;
    logic [NSW-1:0]           r_n;
    logic                     r_side;
    logic                     r_oob;
    logic                     r_hit;
    logic [DIST_W-1:0]        r_perp;
    logic [LNW-1:0]           r_line;
    logic                     r_rd;
    logic                     r_map [DEPTH];

    logic                     r_ov;
    logic [COL_W-1:0]         r_o_col;
    logic [ROW_W-1:0]         r_o_ds;
    logic [ROW_W-1:0]         r_o_de;
    logic                     r_o_side;
    logic [CELL_W-1:0]        r_o_hx;
    logic [CELL_W-1:0]        r_o_hy;
    logic [DIST_W-1:0]        r_o_perp;
    logic                     r_o_nohit;

    logic                     in_acc;
    logic                     map_we;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic [SCR_W-1:0]         w_eff;
    logic [SCR_W-1:0]         h_eff;
    logic [RW-1:0]            mag_rx;
    logic [RW-1:0]            mag_ry;
    logic [FW-1:0]            frac_x;
    logic [FW-1:0]            frac_y;
    logic signed [MA-1:0]     mul_a;
    logic signed [MB-1:0]     mul_b;
    logic                     go_x;
    logic signed [CW-1:0]     n_cx;
    logic signed [CW-1:0]     n_cy;
    logic                     in_map;
    logic signed [CW-1:0]     p_cell;
    logic [POS_W-1:0]         p_pos;
    logic signed [RW-1:0]     p_ray;
    logic [RW-1:0]            p_ray_mag;
    logic signed [PNW-1:0]    p_num;
    logic [PNW-1:0]           p_mag;
    logic                     p_zero_q;
    logic [COL_W-1:0]         h_half;
    logic [LNW-2:0]           l_half;
    logic [LNW-1:0]           de_sum;
    logic [SCR_W-1:0]         h_m1;
    logic [ROW_W-1:0]         ds_val;
    logic [ROW_W-1:0]         de_val;
    logic                     out_free;

    t_div_ctl                 dv_ctl;
    logic [DNW-1:0]           dv_num;
    logic [RW-1:0]            dv_den;
    logic                     dv_done;
    logic [DNW-1:0]           dv_quo;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ov || !i_stall;

    always_comb begin
        w_eff = (r_scr_w == '0) ? SCR_W'(1) : r_scr_w;
        if (r_scr_h == '0) begin
            h_eff = SCR_W'(1);
        end else if (r_scr_h > SCR_W'(H_MAX)) begin
            h_eff = SCR_W'(H_MAX);
        end else begin
            h_eff = r_scr_h;
        end
        mag_rx = r_rx[RW-1] ? RW'(-r_rx) : RW'(r_rx);
        mag_ry = r_ry[RW-1] ? RW'(-r_ry) : RW'(r_ry);
        frac_x = r_rx[RW-1] ? {1'b0, r_pos_x[FRAC_BITS-1:0]}
                            : FW'(ONE_FX) - {1'b0, r_pos_x[FRAC_BITS-1:0]};
        frac_y = r_ry[RW-1] ? {1'b0, r_pos_y[FRAC_BITS-1:0]}
                            : FW'(ONE_FX) - {1'b0, r_pos_y[FRAC_BITS-1:0]};
    end

    always_comb begin
        go_x = (r_sx < r_sy);
        n_cx = r_cx;
        n_cy = r_cy;
        if (go_x) begin
            n_cx = r_rx[RW-1] ? r_cx - CW'(1) : r_cx + CW'(1);
        end else begin
            n_cy = r_ry[RW-1] ? r_cy - CW'(1) : r_cy + CW'(1);
        end
        in_map = !n_cx[CW-1] && !n_cy[CW-1] &&
                 (n_cx < CW'(MAP_SIDE)) && (n_cy < CW'(MAP_SIDE));
        rd_addr = in_map ? AW'(32'(n_cy) * MAP_SIDE + 32'(n_cx)) : '0;
        map_we  = in_acc && (i_opcode == OP_WRITE) &&
                  (32'(i_cell_x) < MAP_SIDE) && (32'(i_cell_y) < MAP_SIDE);
        wr_addr = AW'(32'(i_cell_y) * MAP_SIDE + 32'(i_cell_x));
    end

    always_comb begin
        p_cell    = r_side ? r_cy : r_cx;
        p_pos     = r_side ? r_pos_y : r_pos_x;
        p_ray     = r_side ? r_ry : r_rx;
        p_ray_mag = r_side ? mag_ry : mag_rx;
        p_num     = (PNW'(p_cell) <<< FRAC_BITS) - PNW'(p_pos)
                  + (p_ray[RW-1] ? PNW'(ONE_FX) : PNW'(0));
        p_mag     = p_num[PNW-1] ? PNW'(-p_num) : PNW'(p_num);
        p_zero_q  = (p_num != '0) && (p_num[PNW-1] != p_ray[RW-1]);
    end

    always_comb begin
        h_half = h_eff[SCR_W-1:1];
        l_half = r_line[LNW-1:1];
        h_m1   = h_eff - SCR_W'(1);
        de_sum = LNW'(l_half) + LNW'(h_half);
        ds_val = (l_half > (LNW-1)'(h_half)) ? '0 : ROW_W'(h_half - ROW_W'(l_half));
        de_val = (de_sum > LNW'(h_m1)) ? ROW_W'(h_m1) : ROW_W'(de_sum);
    end

    always_comb begin
        dv_ctl = '0;
        dv_num = '0;
        dv_den = '0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            S_CAM: begin
                dv_ctl.start = 1'b1;
                dv_ctl.count = DIV_CNT_W'(CAM_W);
                dv_num       = DNW'({r_col, 1'b0}) << (DNW - COL2_W);
                dv_den       = RW'(w_eff);
            end
            S_DX: begin
                dv_ctl.start = (r_rx != '0) && (r_ry != '0);
                dv_ctl.count = DIV_CNT_W'(DTW);
                dv_num       = DNW'(1) << (DNW - 1);
                dv_den       = mag_rx;
            end
            S_DY: begin
                dv_ctl.start = (r_rx != '0) && (r_ry != '0);
                dv_ctl.count = DIV_CNT_W'(DTW);
                dv_num       = DNW'(1) << (DNW - 1);
                dv_den       = mag_ry;
            end
            S_PERP: begin
                dv_ctl.start = (p_ray != '0) && !p_zero_q;
                dv_ctl.count = DIV_CNT_W'(DNW);
                dv_num       = DNW'(p_mag) << (DNW - PNW);
                dv_den       = p_ray_mag;
            end
            S_LINE: begin
                dv_ctl.start = 1'b1;
                dv_ctl.count = DIV_CNT_W'(LNW);
                dv_num       = DNW'(h_eff) << (DNW - SCR_W);
                dv_den       = RW'(r_perp);
            end
            S_MX: begin
                mul_a = r_plane_x;
                mul_b = MB'(r_cam);
            end
            S_MY: begin
                mul_a = r_plane_y;
                mul_b = MB'(r_cam);
            end
            S_SX: begin
                mul_a = $signed({2'b00, frac_x});
                mul_b = $signed({1'b0, r_dx});
            end
            S_SY: begin
                mul_a = $signed({2'b00, frac_y});
                mul_b = $signed({1'b0, r_dy});
            end
            default: begin
                dv_ctl = '0;
            end
        endcase
    end

    grc_div #(
        .NW (DNW),
        .DW (RW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dv_ctl),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[wr_addr] <= i_wall;
        end
        r_rd <= r_map[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_dir_x   <= '0;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= '0;
            r_scr_w   <= SCR_W'(640);
            r_scr_h   <= SCR_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POS_X:   r_pos_x   <= i_cfg_data[POS_W-1:0];
                REG_POS_Y:   r_pos_y   <= i_cfg_data[POS_W-1:0];
                REG_DIR_X:   r_dir_x   <= i_cfg_data[VEC_W-1:0];
                REG_DIR_Y:   r_dir_y   <= i_cfg_data[VEC_W-1:0];
                REG_PLANE_X: r_plane_x <= i_cfg_data[VEC_W-1:0];
                REG_PLANE_Y: r_plane_y <= i_cfg_data[VEC_W-1:0];
                REG_SCR_W:   r_scr_w   <= i_cfg_data[SCR_W-1:0];
                REG_SCR_H:   r_scr_h   <= i_cfg_data[SCR_W-1:0];
                default:     r_scr_h   <= r_scr_h;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_n     <= '0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_opcode == OP_CAST) begin
                        r_state <= S_CAM;
                    end
                end
                S_CAM:  r_state <= S_CAMW;
                S_CAMW: begin
                    if (dv_done) begin
                        r_state <= S_MX;
                    end
                end
                S_MX:   r_state <= S_MY;
                S_MY:   r_state <= S_RY;
                S_RY:   r_state <= S_DX;
                S_DX:   r_state <= dv_ctl.start ? S_DXW : S_DY;
                S_DXW: begin
                    if (dv_done) begin
                        r_state <= S_DY;
                    end
                end
                S_DY:   r_state <= dv_ctl.start ? S_DYW : S_SX;
                S_DYW: begin
                    if (dv_done) begin
                        r_state <= S_SX;
                    end
                end
                S_SX: begin
                    r_n     <= '0;
                    r_state <= S_SY;
                end
                S_SY:   r_state <= S_SYW;
                S_SYW:  r_state <= S_STEP;
                S_STEP: begin
                    r_n     <= r_n + NSW'(1);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_oob || r_rd) begin
                        r_state <= S_PERP;
                    end else if (r_n == NSW'(MAX_STEPS)) begin
                        r_state <= S_LINE;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_PERP: r_state <= dv_ctl.start ? S_PERPW : S_LINE;
                S_PERPW: begin
                    if (dv_done) begin
                        r_state <= S_LINE;
                    end
                end
                S_LINE: r_state <= S_LINEW;
                S_LINEW: begin
                    if (dv_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_col <= i_column;
                end
            end
            S_CAMW: begin
                if (dv_done) begin
                    r_cam <= $signed({1'b0, dv_quo[CAM_W-1:0]}) - CMW'(ONE_FX);
                end
            end
            S_MY: r_rx <= RW'(r_dir_x) + RW'(r_prod >>> FRAC_BITS);
            S_RY: r_ry <= RW'(r_dir_y) + RW'(r_prod >>> FRAC_BITS);
            S_DX: begin
                if (r_ry == '0) begin
                    r_dx <= '0;
                end else if (r_rx == '0) begin
                    r_dx <= DTW'(ONE_FX);
                end
            end
            S_DXW: begin
                if (dv_done) begin
                    r_dx <= dv_quo[DTW-1:0];
                end
            end
            S_DY: begin
                if (r_rx == '0) begin
                    r_dy <= '0;
                end else if (r_ry == '0) begin
                    r_dy <= DTW'(ONE_FX);
                end
            end
            S_DYW: begin
                if (dv_done) begin
                    r_dy <= dv_quo[DTW-1:0];
                end
            end
            S_SX: begin
                r_cx   <= CW'(r_pos_x[POS_W-1:FRAC_BITS]);
                r_cy   <= CW'(r_pos_y[POS_W-1:FRAC_BITS]);
                r_side <= 1'b0;
            end
            S_SY:  r_sx <= SW'(r_prod[FRAC_BITS +: DTW]);
            S_SYW: r_sy <= SW'(r_prod[FRAC_BITS +: DTW]);
            S_STEP: begin
                r_cx   <= n_cx;
                r_cy   <= n_cy;
                r_side <= !go_x;
                r_oob  <= !in_map;
                if (go_x) begin
                    r_sx <= r_sx + SW'(r_dx);
                end else begin
                    r_sy <= r_sy + SW'(r_dy);
                end
            end
            S_CHK: begin
                if (r_oob || r_rd) begin
                    r_hit <= 1'b1;
                end else if (r_n == NSW'(MAX_STEPS)) begin
                    r_hit  <= 1'b0;
                    r_perp <= '1;
                    r_side <= 1'b0;
                    r_cx   <= '0;
                    r_cy   <= '0;
                end
            end
            S_PERP: begin
                if (p_ray == '0) begin
                    r_perp <= '1;
                end else if (p_zero_q) begin
                    r_perp <= DIST_W'(1);
                end
            end
            S_PERPW: begin
                if (dv_done) begin
                    if (|dv_quo[DNW-1:DIST_W]) begin
                        r_perp <= '1;
                    end else if (dv_quo == '0) begin
                        r_perp <= DIST_W'(1);
                    end else begin
                        r_perp <= dv_quo[DIST_W-1:0];
                    end
                end
            end
            S_LINEW: begin
                if (dv_done) begin
                    r_line <= dv_quo[LNW-1:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_col   <= r_col;
                    r_o_ds    <= ds_val;
                    r_o_de    <= de_val;
                    r_o_side  <= r_side;
                    r_o_hx    <= r_cx[CELL_W-1:0];
                    r_o_hy    <= r_cy[CELL_W-1:0];
                    r_o_perp  <= r_perp;
                    r_o_nohit <= !r_hit;
                end
            end
            default: begin
                r_line <= r_line;
            end
        endcase
    end

    assign o_valid      = r_ov;
    assign o_column_out = r_o_col;
    assign o_draw_start = r_o_ds;
    assign o_draw_end   = r_o_de;
    assign o_side       = r_o_side;
    assign o_hit_x      = r_o_hx;
    assign o_hit_y      = r_o_hy;
    assign o_perp_dist  = r_o_perp;
    assign o_no_hit     = r_o_nohit;

    a_no_hit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_no_hit |-> o_perp_dist == '1 && !o_side && o_hit_x == '0 && o_hit_y == '0)
        else $error("no-hit result carries hit data");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_draw_start <= o_draw_end)
        else $error("draw span is inverted");

    a_dist_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_no_hit |-> o_perp_dist != '0)
        else $error("hit distance is zero");

    a_step_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NSW'(MAX_STEPS))
        else $error("step counter passed the limit");

endmodule

[rtl/grc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_div: bit-serial restoring divider
// Produces one quotient bit per cycle. The numerator arrives aligned to the
// top of the word and the count gives the number of quotient bits.
// ----------------------------------------------------------------------------
module grc_div import grc_pkg::*; #(
    parameter int NW = 42,
    parameter int DW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_ctl      i_ctl,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    logic [NW-1:0]        r_quo;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DW:0]          w_cat;
    logic                 w_ge;
    logic [DW-1:0]        n_rem;

    always_comb begin
        w_cat = {r_rem, r_quo[NW-1]};
        w_ge  = (w_cat >= {1'b0, r_den});
        n_rem = w_ge ? DW'(w_cat - {1'b0, r_den}) : w_cat[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
